// ----- src/array_doubly_linked_list_top_assert.svh -----
// assertion macros for the linked list block
`ifndef ARRAY_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH
`define ARRAY_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH

// same-cycle implication
`define ADLL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ADLL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/adll_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package adll_pkg;

  localparam int CMD_W    = 3;
  localparam int HANDLE_W = 11;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD  = 3'd0,
    CMD_INS_TAIL  = 3'd1,
    CMD_DELETE    = 3'd2,
    CMD_INS_LEFT  = 3'd3,
    CMD_INS_RIGHT = 3'd4,
    CMD_READ_NEXT = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BAD   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // link store control
  typedef struct packed {
    logic rd_en;
    logic wr_left;
    logic wr_right;
  } link_ctl_t;

endpackage
`default_nettype wire

// ----- src/adll_link_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
module adll_link_store #(
  parameter int DEPTH = 1026,
  parameter int SW    = 11
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire adll_pkg::link_ctl_t ctl,
  input  wire  [SW-1:0]           rd_addr_l,
  input  wire  [SW-1:0]           rd_addr_r,
  input  wire  [SW-1:0]           wr_addr_l,
  input  wire  [SW-1:0]           wr_data_l,
  input  wire  [SW-1:0]           wr_addr_r,
  input  wire  [SW-1:0]           wr_data_r,
  output logic [SW-1:0]           rd_data_l,
  output logic [SW-1:0]           rd_data_r
);
  import adll_pkg::*;

  localparam logic [SW-1:0] HEAD_SLOT = '0;
  localparam logic [SW-1:0] TAIL_SLOT = SW'(1);

  logic [SW-1:0] mem_l [DEPTH];
  logic [SW-1:0] mem_r [DEPTH];
  logic [SW-1:0] lq_r, rq_r;
  logic          tl_valid_r, hr_valid_r;
  logic          lsent_r, rsent_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_left) begin
      mem_l[wr_addr_l] <= wr_data_l;
    end
    if (ctl.wr_right) begin
      mem_r[wr_addr_r] <= wr_data_r;
    end
    if (ctl.rd_en) begin
      lq_r <= mem_l[rd_addr_l];
      rq_r <= mem_r[rd_addr_r];
    end
  end

  // sentinel links read as their reset values until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_valid_r <= 1'b0;
      hr_valid_r <= 1'b0;
      lsent_r    <= 1'b0;
      rsent_r    <= 1'b0;
    end else begin
      if (ctl.wr_left && wr_addr_l == TAIL_SLOT) begin
        tl_valid_r <= 1'b1;
      end
      if (ctl.wr_right && wr_addr_r == HEAD_SLOT) begin
        hr_valid_r <= 1'b1;
      end
      if (ctl.rd_en) begin
        lsent_r <= (rd_addr_l == TAIL_SLOT) && !tl_valid_r;
        rsent_r <= (rd_addr_r == HEAD_SLOT) && !hr_valid_r;
      end
    end
  end

  assign rd_data_l = lsent_r ? HEAD_SLOT : lq_r;
  assign rd_data_r = rsent_r ? TAIL_SLOT : rq_r;

endmodule
`default_nettype wire

// ----- src/adll_value_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
module adll_value_store #(
  parameter int DEPTH = 1026,
  parameter int SW    = 11
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire  [SW-1:0]                wr_addr,
  input  wire  [adll_pkg::VALUE_W-1:0] wr_data,
  input  wire                          rd_en,
  input  wire  [SW-1:0]                rd_addr,
  output logic [adll_pkg::VALUE_W-1:0] rd_data
);
  import adll_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  assign rd_data = q_r;

endmodule
`default_nettype wire

// ----- src/array_doubly_linked_list_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Doubly linked list in a fixed node pool, one command per request. A request is taken when
// start is high and busy is low; its result shows on the out_ ports for exactly one cycle with
// out_valid high and cannot be held off, so the user must capture it then. Inserts, deletes and
// successful read-next requests pass through the EXEC and FIN states before their registered result;
// failed requests, empty-list reads and unused codes go from EXEC back to idle and skip FIN. A
// new request can be taken in the cycle its predecessor's result is shown. FIN is needed
// because each link memory has a single write port: an insert writes two links on each side, and
// a delete writes one left link and two right links.
// Node values and links live in block memories with no clearing pass after reset.
module array_doubly_linked_list_top #(
  parameter int POOL_NODES = 1024
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire  [adll_pkg::CMD_W-1:0]    in_command,
  input  wire  [adll_pkg::HANDLE_W-1:0] in_handle,
  input  wire  [adll_pkg::VALUE_W-1:0]  in_item_value,
  output logic                          out_valid,
  output logic [adll_pkg::STATUS_W-1:0] out_status,
  output logic [adll_pkg::HANDLE_W-1:0] out_new_handle,
  output logic [adll_pkg::VALUE_W-1:0]  out_read_value,
  output logic                          out_last
);
  import adll_pkg::*;

  localparam int SLOTS = POOL_NODES + 2;
  localparam int SW    = $clog2(SLOTS);
  localparam int NFW   = $clog2(SLOTS + 1);
  localparam logic [SW-1:0]  HEAD_SLOT = '0;
  localparam logic [SW-1:0]  TAIL_SLOT = SW'(1);
  localparam logic [NFW-1:0] FIRST_FREE = NFW'(2);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic                 hok_r, hok_nxt;
  logic [VALUE_W-1:0]   val_r;
  logic [SW-1:0]        at_r, at_nxt;
  logic [SW-1:0]        nx_r, nx_nxt;
  logic [NFW-1:0]       nfree_r, nfree_nxt;
  logic [SW-1:0]        cursor_r, cursor_nxt;

  logic                 ovalid_r, ovalid_nxt;
  logic [STATUS_W-1:0]  ostatus_r, ostatus_nxt;
  logic [HANDLE_W-1:0]  ohandle_r, ohandle_nxt;
  logic [VALUE_W-1:0]   ovalue_r, ovalue_nxt;
  logic                 olast_r, olast_nxt;

  link_ctl_t            lctl;
  logic [SW-1:0]        rd_addr_l, rd_addr_r;
  logic [SW-1:0]        wr_addr_l, wr_data_l, wr_addr_r, wr_data_r;
  logic [SW-1:0]        ldata, rdata;
  logic                 v_we, v_re;
  logic [SW-1:0]        v_waddr, v_raddr;
  logic [VALUE_W-1:0]   v_rdata;

  logic                 accept;
  logic [31:0]          hx;
  logic                 in_hok;
  logic                 full;
  logic                 live;
  logic [SW-1:0]        new_slot;
  logic [HANDLE_W-1:0]  new_handle;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign hx        = 32'(in_handle);
  assign in_hok    = (hx >= 32'd1) && (hx <= 32'(POOL_NODES)) && (hx + 32'd1 < 32'(nfree_r));
  assign full      = (nfree_r == NFW'(SLOTS));
  assign live      = hok_r && (rdata != slot_r);
  assign new_slot  = SW'(nfree_r);
  assign new_handle = HANDLE_W'(32'(nfree_r) - 32'd1);

  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    hok_nxt     = hok_r;
    at_nxt      = at_r;
    nx_nxt      = nx_r;
    nfree_nxt   = nfree_r;
    cursor_nxt  = cursor_r;
    ovalid_nxt  = 1'b0;
    ostatus_nxt = ST_OK;
    ohandle_nxt = '0;
    ovalue_nxt  = '0;
    olast_nxt   = 1'b0;
    lctl        = '0;
    rd_addr_l   = '0;
    rd_addr_r   = '0;
    wr_addr_l   = '0;
    wr_data_l   = '0;
    wr_addr_r   = '0;
    wr_data_r   = '0;
    v_we        = 1'b0;
    v_re        = 1'b0;
    v_waddr     = new_slot;
    v_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          slot_nxt   = SW'(hx + 32'd1);
          hok_nxt    = in_hok;
          lctl.rd_en = 1'b1;
          case (in_command)
            CMD_INS_HEAD:  rd_addr_r = HEAD_SLOT;
            CMD_INS_TAIL:  rd_addr_l = TAIL_SLOT;
            CMD_READ_NEXT: rd_addr_r = cursor_r;
            default: begin
              rd_addr_l = SW'(hx + 32'd1);
              rd_addr_r = SW'(hx + 32'd1);
            end
          endcase
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r) inside
          CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_LEFT, CMD_INS_RIGHT: begin
            if ((cmd_r == CMD_INS_LEFT || cmd_r == CMD_INS_RIGHT) && !live) begin
              ovalid_nxt  = 1'b1;
              ostatus_nxt = ST_BAD;
              state_nxt   = S_IDLE;
            end else if (full) begin
              ovalid_nxt  = 1'b1;
              ostatus_nxt = ST_FULL;
              state_nxt   = S_IDLE;
            end else begin
              case (cmd_r)
                CMD_INS_HEAD: begin
                  at_nxt = HEAD_SLOT;
                  nx_nxt = rdata;
                end
                CMD_INS_TAIL: begin
                  at_nxt = ldata;
                  nx_nxt = TAIL_SLOT;
                end
                CMD_INS_LEFT: begin
                  at_nxt = ldata;
                  nx_nxt = slot_r;
                end
                default: begin
                  at_nxt = slot_r;
                  nx_nxt = rdata;
                end
              endcase
              v_we          = 1'b1;
              lctl.wr_left  = 1'b1;
              lctl.wr_right = 1'b1;
              wr_addr_l     = new_slot;
              wr_data_l     = at_nxt;
              wr_addr_r     = new_slot;
              wr_data_r     = nx_nxt;
              state_nxt     = S_FIN;
            end
          end
          CMD_DELETE: begin
            if (!live) begin
              ovalid_nxt  = 1'b1;
              ostatus_nxt = ST_BAD;
              state_nxt   = S_IDLE;
            end else begin
              lctl.wr_left  = 1'b1;
              lctl.wr_right = 1'b1;
              wr_addr_r     = ldata;
              wr_data_r     = rdata;
              wr_addr_l     = rdata;
              wr_data_l     = ldata;
              state_nxt     = S_FIN;
            end
          end
          CMD_READ_NEXT: begin
            if (rdata == TAIL_SLOT) begin
              ovalid_nxt  = 1'b1;
              ostatus_nxt = ST_EMPTY;
              state_nxt   = S_IDLE;
            end else begin
              nx_nxt     = rdata;
              lctl.rd_en = 1'b1;
              rd_addr_r  = rdata;
              v_re       = 1'b1;
              v_raddr    = rdata;
              state_nxt  = S_FIN;
            end
          end
          default: begin
            ovalid_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      S_FIN: begin
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
        if (cmd_r == CMD_READ_NEXT) begin
          ovalue_nxt = v_rdata;
          olast_nxt  = (rdata == TAIL_SLOT);
          cursor_nxt = (rdata == TAIL_SLOT) ? HEAD_SLOT : nx_r;
        end else if (cmd_r == CMD_DELETE) begin
          // a deleted node links right to itself
          lctl.wr_right = 1'b1;
          wr_addr_r     = slot_r;
          wr_data_r     = slot_r;
          cursor_nxt    = HEAD_SLOT;
        end else begin
          lctl.wr_left  = 1'b1;
          lctl.wr_right = 1'b1;
          wr_addr_r     = at_r;
          wr_data_r     = new_slot;
          wr_addr_l     = nx_r;
          wr_data_l     = new_slot;
          ohandle_nxt   = new_handle;
          nfree_nxt     = nfree_r + NFW'(1);
          cursor_nxt    = HEAD_SLOT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      nfree_r  <= FIRST_FREE;
      cursor_r <= HEAD_SLOT;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      nfree_r  <= nfree_nxt;
      cursor_r <= cursor_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      val_r <= in_item_value;
    end
    slot_r    <= slot_nxt;
    hok_r     <= hok_nxt;
    at_r      <= at_nxt;
    nx_r      <= nx_nxt;
    ostatus_r <= ostatus_nxt;
    ohandle_r <= ohandle_nxt;
    ovalue_r  <= ovalue_nxt;
    olast_r   <= olast_nxt;
  end

  adll_link_store #(
    .DEPTH (SLOTS),
    .SW    (SW)
  ) u_links (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lctl),
    .rd_addr_l (rd_addr_l),
    .rd_addr_r (rd_addr_r),
    .wr_addr_l (wr_addr_l),
    .wr_data_l (wr_data_l),
    .wr_addr_r (wr_addr_r),
    .wr_data_r (wr_data_r),
    .rd_data_l (ldata),
    .rd_data_r (rdata)
  );

  adll_value_store #(
    .DEPTH (SLOTS),
    .SW    (SW)
  ) u_values (
    .clk     (clk),
    .wr_en   (v_we),
    .wr_addr (v_waddr),
    .wr_data (val_r),
    .rd_en   (v_re),
    .rd_addr (v_raddr),
    .rd_data (v_rdata)
  );

  assign out_valid      = ovalid_r;
  assign out_status     = ostatus_r;
  assign out_new_handle = ohandle_r;
  assign out_read_value = ovalue_r;
  assign out_last       = olast_r;

endmodule
`default_nettype wire

// ----- src/adll_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "array_doubly_linked_list_top_assert.svh"
module adll_chk (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           start,
  input wire                           busy,
  input wire  [adll_pkg::CMD_W-1:0]    in_command,
  input wire  [adll_pkg::HANDLE_W-1:0] in_handle,
  input wire  [adll_pkg::VALUE_W-1:0]  in_item_value,
  input wire                           out_valid,
  input wire  [adll_pkg::STATUS_W-1:0] out_status,
  input wire  [adll_pkg::HANDLE_W-1:0] out_new_handle,
  input wire  [adll_pkg::VALUE_W-1:0]  out_read_value,
  input wire                           out_last
);
  import adll_pkg::*;

  `ADLL_ASSERT_NXT(a_accept_busy, start && !busy, busy, "no busy after request")
  `ADLL_ASSERT_IMP(a_result_after_busy, out_valid, $past(busy), "result without request")
  `ADLL_ASSERT_IMP(a_handle_ok, out_valid && out_new_handle != '0, out_status == ST_OK, "handle on failed insert")
  `ADLL_ASSERT_IMP(a_last_ok, out_valid && out_last, out_status == ST_OK && out_new_handle == '0, "bad last flag")

endmodule

bind array_doubly_linked_list_top adll_chk u_adll_chk (.*);
`default_nettype wire

// ----- tb/sv/list_reply_checker.sv -----
`timescale 1ns / 1ps
module list_reply_checker
  import adll_pkg::*;
#(
  parameter int POOL_NODES = 1024
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire                 busy,
  input  wire  [CMD_W-1:0]    in_command,
  input  wire  [HANDLE_W-1:0] in_handle,
  input  wire  [VALUE_W-1:0]  in_item_value,
  input  wire                 out_valid,
  input  wire  [STATUS_W-1:0] out_status,
  input  wire  [HANDLE_W-1:0] out_new_handle,
  input  wire  [VALUE_W-1:0]  out_read_value,
  input  wire                 out_last,
  output int unsigned         mismatches,
  output int unsigned         pending
);

  typedef logic [HANDLE_W-1:0] slot_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    status_t             status;
    logic [HANDLE_W-1:0] new_handle;
    logic [VALUE_W-1:0]  read_value;
    logic                last;
  } list_reply_t;

  localparam int    SLOTS      = POOL_NODES + 2;
  localparam slot_t HEAD_SLOT  = slot_t'(0);
  localparam slot_t TAIL_SLOT  = slot_t'(1);
  localparam slot_t SLOT_LIMIT = slot_t'(POOL_NODES + 2);
  localparam slot_t MAX_HANDLE = slot_t'(POOL_NODES);

  logic [VALUE_W-1:0] slot_value [SLOTS];
  slot_t              prev_slot  [SLOTS];
  slot_t              next_slot  [SLOTS];
  bit                 slot_live  [SLOTS];
  slot_t              free_slot;
  slot_t              walk_pos;

  list_reply_t expected_replies [$];
  int unsigned fail_cnt = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic void clear_list();
    for (int i = 0; i < SLOTS; i++) begin
      slot_value[i] = '0;
      prev_slot[i]  = '0;
      next_slot[i]  = '0;
      slot_live[i]  = 1'b0;
    end
    next_slot[HEAD_SLOT] = TAIL_SLOT;
    prev_slot[TAIL_SLOT] = HEAD_SLOT;
    free_slot = slot_t'(2);
    walk_pos  = HEAD_SLOT;
  endfunction

  // slot of a live handle, zero when the handle is unusable
  function automatic slot_t target_slot(slot_t h);
    if (h == '0 || h > MAX_HANDLE) return '0;
    if (h + slot_t'(1) >= free_slot) return '0;
    if (!slot_live[h + slot_t'(1)]) return '0;
    return h + slot_t'(1);
  endfunction

  function automatic status_t splice_after(slot_t at, logic [VALUE_W-1:0] v,
                                           output slot_t nh);
    slot_t s;
    slot_t nxt;
    nh = '0;
    if (free_slot >= SLOT_LIMIT) return ST_FULL;
    s   = free_slot;
    nxt = next_slot[at];
    slot_value[s] = v;
    next_slot[s]  = nxt;
    prev_slot[s]  = at;
    next_slot[at] = s;
    prev_slot[nxt] = s;
    slot_live[s]  = 1'b1;
    free_slot     = s + slot_t'(1);
    walk_pos      = HEAD_SLOT;
    nh            = s - slot_t'(1);
    return ST_OK;
  endfunction

  function automatic list_reply_t apply_request(logic [CMD_W-1:0] cmd, slot_t h,
                                                logic [VALUE_W-1:0] v);
    list_reply_t r;
    slot_t       s;
    slot_t       nh;
    slot_t       nxt;
    r     = '0;
    nh    = '0;
    r.cmd = cmd;
    r.status = ST_OK;
    case (cmd)
      CMD_INS_HEAD: begin
        r.status = splice_after(HEAD_SLOT, v, nh);
      end
      CMD_INS_TAIL: begin
        r.status = splice_after(prev_slot[TAIL_SLOT], v, nh);
      end
      CMD_DELETE: begin
        s = target_slot(h);
        if (s == '0) begin
          r.status = ST_BAD;
        end else begin
          next_slot[prev_slot[s]] = next_slot[s];
          prev_slot[next_slot[s]] = prev_slot[s];
          slot_live[s] = 1'b0;
          walk_pos = HEAD_SLOT;
        end
      end
      CMD_INS_LEFT: begin
        s = target_slot(h);
        if (s == '0) r.status = ST_BAD;
        else r.status = splice_after(prev_slot[s], v, nh);
      end
      CMD_INS_RIGHT: begin
        s = target_slot(h);
        if (s == '0) r.status = ST_BAD;
        else r.status = splice_after(s, v, nh);
      end
      CMD_READ_NEXT: begin
        nxt = next_slot[walk_pos];
        if (nxt == TAIL_SLOT) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_value = slot_value[nxt];
          if (next_slot[nxt] == TAIL_SLOT) begin
            r.last   = 1'b1;
            walk_pos = HEAD_SLOT;
          end else begin
            walk_pos = nxt;
          end
        end
      end
      default: ;
    endcase
    r.new_handle = nh;
    return r;
  endfunction

  function automatic void flag(string msg);
    if (fail_cnt < 10) $display("%s", msg);
    fail_cnt++;
  endfunction

  always @(posedge clk) begin
    list_reply_t want;
    list_reply_t got;
    if (!rst_n) begin
      clear_list();
      expected_replies.delete();
      pending <= 0;
    end else begin
      if (out_valid) begin
        got = '0;
        got.status     = status_t'(out_status);
        got.new_handle = out_new_handle;
        got.read_value = out_read_value;
        got.last       = out_last;
        if (expected_replies.size() == 0) begin
          flag($sformatf("unexpected reply: status %0d handle %0d value %h last %0b",
                         got.status, got.new_handle, got.read_value, got.last));
        end else begin
          want = expected_replies.pop_front();
          got.cmd = want.cmd;
          if (got != want)
            flag($sformatf({"mismatch on command %0d: expected status %0d handle %0d ",
                            "value %h last %0b, got status %0d handle %0d value %h last %0b"},
                           want.cmd, want.status, want.new_handle, want.read_value,
                           want.last, got.status, got.new_handle, got.read_value,
                           got.last));
        end
      end
      if (start && !busy)
        expected_replies.push_back(apply_request(in_command, in_handle, in_item_value));
      pending <= expected_replies.size();
    end
    mismatches <= fail_cnt;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import adll_pkg::*;

  localparam int POOL = 1024;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int HANDLE_MAX = (1 << HANDLE_W) - 1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [CMD_W-1:0]    in_command = '0;
  logic [HANDLE_W-1:0] in_handle = '0;
  logic [VALUE_W-1:0]  in_item_value = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_new_handle;
  logic [VALUE_W-1:0]  out_read_value;
  logic                out_last;
  int unsigned         mismatch_total;
  int unsigned         pending_replies;
  int unsigned         cycle_count = 0;

  int idle_pct = 0;
  int live_handles [$];
  bit handle_live [0:HANDLE_MAX];
  int allocated = 0;
  int phase_idle [4] = '{0, 50, 0, 9};

  always #10 clk = ~clk;

  array_doubly_linked_list_top #(
    .POOL_NODES(POOL)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_handle     (in_handle),
    .in_item_value (in_item_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_new_handle(out_new_handle),
    .out_read_value(out_read_value),
    .out_last      (out_last)
  );

  list_reply_checker #(
    .POOL_NODES(POOL)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_handle     (in_handle),
    .in_item_value (in_item_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_new_handle(out_new_handle),
    .out_read_value(out_read_value),
    .out_last      (out_last),
    .mismatches    (mismatch_total),
    .pending       (pending_replies)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one request through the handshake, plus tracking of live handles
  task automatic run_cmd(input logic [CMD_W-1:0] cmd, input int h_in,
                         input logic [VALUE_W-1:0] v);
    int h;
    bit target_ok;
    h = h_in & HANDLE_MAX;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_handle     <= HANDLE_W'(h);
    in_item_value <= v;
    do @(posedge clk); while (busy);
    target_ok = (cmd == CMD_INS_LEFT || cmd == CMD_INS_RIGHT) ? handle_live[h] : 1'b1;
    if ((cmd == CMD_INS_HEAD || cmd == CMD_INS_TAIL || cmd == CMD_INS_LEFT ||
         cmd == CMD_INS_RIGHT) && target_ok && allocated < POOL) begin
      allocated++;
      handle_live[allocated] = 1'b1;
      live_handles.push_back(allocated);
    end
    if (cmd == CMD_DELETE && handle_live[h]) begin
      handle_live[h] = 1'b0;
      for (int i = 0; i < live_handles.size(); i++) begin
        if (live_handles[i] == h) begin
          live_handles.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_replies != 0);
  endtask

  function automatic int pick_live();
    if (live_handles.size() == 0) return $urandom_range(0, HANDLE_MAX);
    return live_handles[$urandom_range(0, live_handles.size() - 1)];
  endfunction

  task automatic random_cmd();
    int len;
    int r;
    int ins_pct;
    int del_pct;
    len = live_handles.size();
    ins_pct = (len > 24) ? 30 : 50;
    del_pct = (len > 24) ? 45 : 15;
    r = $urandom_range(0, 99);
    if (len <= 24 && $urandom_range(0, 49) == 0) begin
      // walk the whole list and wrap around
      repeat (len + 2) run_cmd(CMD_READ_NEXT, $urandom_range(0, HANDLE_MAX), $urandom);
    end else if (r < 4) begin
      case ($urandom_range(0, 3))
        0: run_cmd($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B,
                   $urandom_range(0, HANDLE_MAX), $urandom);
        1: run_cmd(CMD_DELETE, $urandom_range(0, HANDLE_MAX), $urandom);
        2: run_cmd($urandom_range(0, 1) ? CMD_INS_LEFT : CMD_INS_RIGHT,
                   $urandom_range(0, HANDLE_MAX), $urandom);
        default: run_cmd(CMD_DELETE, $urandom_range(0, allocated + 1), $urandom);
      endcase
    end else if (r < 4 + ins_pct) begin
      case ($urandom_range(0, 3))
        0: run_cmd(CMD_INS_HEAD, $urandom_range(0, HANDLE_MAX), $urandom);
        1: run_cmd(CMD_INS_TAIL, $urandom_range(0, HANDLE_MAX), $urandom);
        2: run_cmd(CMD_INS_LEFT, pick_live(), $urandom);
        default: run_cmd(CMD_INS_RIGHT, pick_live(), $urandom);
      endcase
    end else if (r < 4 + ins_pct + del_pct) begin
      run_cmd(CMD_DELETE, pick_live(), $urandom);
    end else begin
      run_cmd(CMD_READ_NEXT, $urandom_range(0, HANDLE_MAX), $urandom);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, unknown handles, unused codes, then a small list
    run_cmd(CMD_READ_NEXT, 0, 32'h0);
    run_cmd(CMD_DELETE, 1, 32'h0);
    run_cmd(CMD_INS_LEFT, 0, 32'h0);
    run_cmd(CMD_INS_RIGHT, 1, 32'h0);
    run_cmd(CMD_SPARE_A, HANDLE_MAX, 32'hffff_ffff);
    run_cmd(CMD_SPARE_B, POOL, 32'h0000_0001);
    run_cmd(CMD_INS_HEAD, HANDLE_MAX, 32'h8000_0000);
    run_cmd(CMD_READ_NEXT, 0, 32'h0);
    run_cmd(CMD_READ_NEXT, 0, 32'h0);
    run_cmd(CMD_INS_TAIL, 0, 32'h7fff_ffff);
    run_cmd(CMD_INS_LEFT, 2, 32'h0);
    run_cmd(CMD_INS_RIGHT, 1, 32'hffff_ffff);
    repeat (5) run_cmd(CMD_READ_NEXT, 0, 32'h0);
    run_cmd(CMD_DELETE, 3, 32'h0);
    run_cmd(CMD_DELETE, 3, 32'h0);
    run_cmd(CMD_INS_RIGHT, 3, 32'h1234_5678);
    run_cmd(CMD_DELETE, POOL, 32'h0);
    run_cmd(CMD_DELETE, HANDLE_MAX, 32'h0);
    run_cmd(CMD_DELETE, 1, 32'h0);
    run_cmd(CMD_READ_NEXT, 0, 32'h0);
    run_cmd(CMD_DELETE, 4, 32'h0);
    run_cmd(CMD_DELETE, 2, 32'h0);
    run_cmd(CMD_READ_NEXT, 0, 32'h0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      repeat (240) random_cmd();
      drain();
    end

    // use up the pool, then push against the full limit
    idle_pct = 9;
    while (allocated < POOL) begin
      if ($urandom_range(0, 9) == 0)
        run_cmd(CMD_READ_NEXT, $urandom_range(0, HANDLE_MAX), $urandom);
      else if ($urandom_range(0, 1) == 0)
        run_cmd(CMD_INS_TAIL, $urandom_range(0, HANDLE_MAX), $urandom);
      else
        run_cmd(CMD_INS_RIGHT, pick_live(), $urandom);
    end
    run_cmd(CMD_INS_RIGHT, POOL, $urandom);
    run_cmd(CMD_INS_LEFT, HANDLE_MAX, $urandom);
    run_cmd(CMD_INS_HEAD, 0, $urandom);
    run_cmd(CMD_INS_TAIL, 0, $urandom);
    run_cmd(CMD_DELETE, POOL, 32'h0);
    run_cmd(CMD_DELETE, POOL, 32'h0);
    run_cmd(CMD_INS_LEFT, pick_live(), $urandom);
    repeat (60) random_cmd();
    drain();

    repeat (8) @(posedge clk);
    if (mismatch_total == 0 && pending_replies == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
